>>> hw/rtl/gls_pkg.sv
// Shared types and constants for the stereo linear-ramp gain block.
package gls_pkg;

    localparam int SampleWidth = 16;
    localparam int GainWidth   = 32;
    localparam int ProdWidth   = SampleWidth + GainWidth;
    localparam int GainShift   = 16;
    localparam int NumLanes    = 2;

    localparam logic signed [GainWidth-1:0] GainUnity = 32'sd65536;
    localparam logic signed [GainWidth+1:0] RampStep  = 34'sd1;

    typedef logic signed [SampleWidth-1:0] t_sample;
    typedef logic signed [GainWidth-1:0]   t_gain;
    typedef logic signed [ProdWidth-1:0]   t_prod;

    // Stage controls shared by the lanes.
    typedef struct packed {
        logic load_prod;
        logic load_out;
    } t_lane_ctrl;

    // Ramp unit result for the word being accepted.
    typedef struct packed {
        logic  drop;
        t_gain gain;
    } t_ramp_stat;

endpackage

>>> hw/rtl/gls_if.sv
// Stream interfaces for sample pairs in and scaled pairs out.
interface gls_in_if import gls_pkg::*;;
    logic    valid;
    logic    ready;
    t_sample sample_low;
    t_sample sample_high;

    modport source (output valid, output sample_low, output sample_high, input ready);
    modport sink   (input valid, input sample_low, input sample_high, output ready);
endinterface

interface gls_out_if import gls_pkg::*;;
    logic    valid;
    logic    ready;
    t_sample out_low;
    t_sample out_high;

    modport source (output valid, output out_low, output out_high, input ready);
    modport sink   (input valid, input out_low, input out_high, output ready);
endinterface

>>> hw/rtl/gls_ramp.sv
// Target register and current gain with one-step linear ramp.
module gls_ramp import gls_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  t_gain      i_cfg_wr_data,
    input  logic       i_accept,
    output t_ramp_stat o_stat
);

    t_gain r_target;
    t_gain r_gain;
    t_gain n_gain;

    logic signed [GainWidth+1:0] cur_ext;
    logic signed [GainWidth+1:0] tgt_ext;

    always_comb begin
        cur_ext = {{2{r_gain[GainWidth-1]}}, r_gain};
        tgt_ext = {{2{r_target[GainWidth-1]}}, r_target};
        n_gain  = r_gain;
        // step only when more than one away
        if (cur_ext < tgt_ext - RampStep) begin
            n_gain = r_gain + GainWidth'(1);
        end else if (cur_ext > tgt_ext + RampStep) begin
            n_gain = r_gain - GainWidth'(1);
        end
        o_stat.drop = (r_gain == '0) && (r_target == '0);
        o_stat.gain = n_gain;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= GainUnity;
            r_gain   <= GainUnity;
        end else begin
            if (i_cfg_wr_en) begin
                r_target <= i_cfg_wr_data;
            end
            if (i_accept && !o_stat.drop) begin
                r_gain <= n_gain;
            end
        end
    end

endmodule

>>> hw/rtl/gls_lane.sv
// One channel: gain multiply, then floor shift and saturation.
module gls_lane import gls_pkg::*; (
    input  logic       i_clk,
    input  t_lane_ctrl i_ctrl,
    input  t_gain      i_gain,
    input  t_sample    i_sample,
    output t_sample    o_sample
);

    t_prod   r_prod;
    t_sample r_out;
    t_sample n_out;

    logic signed [ProdWidth-GainShift-1:0] shifted;

    always_comb begin
        shifted = r_prod[ProdWidth-1:GainShift];
        // clamp when the upper bits are not all copies of the sign
        if (shifted[ProdWidth-GainShift-1:SampleWidth-1] == '0 ||
            shifted[ProdWidth-GainShift-1:SampleWidth-1] == '1) begin
            n_out = shifted[SampleWidth-1:0];
        end else if (shifted[ProdWidth-GainShift-1]) begin
            n_out = {1'b1, {(SampleWidth-1){1'b0}}};
        end else begin
            n_out = {1'b0, {(SampleWidth-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_prod) begin
            r_prod <= ProdWidth'(i_gain) * ProdWidth'(i_sample);
        end
        if (i_ctrl.load_out) begin
            r_out <= n_out;
        end
    end

    assign o_sample = r_out;

endmodule

>>> hw/rtl/gain_ramp_linear_stereo.sv
// Top level: stereo gain with a linear Q16.16 ramp.
//
// i_in carries one stereo word per handshake (sample_low, sample_high, signed
// 16 bit); o_out returns the scaled and saturated pair. i_cfg_wr_en with
// i_cfg_wr_data writes the signed Q16.16 target gain; write it only while the
// block is empty. The current gain moves by one LSB toward the target on each
// word unless it is within one of it. A word taken while both gain and target
// are zero is dropped and yields no output.
// Between input handshake and o_out.valid lie one register for the sample and
// ramped gain, one for the 32x16 product in each lane, one for the saturated
// output. Throughput is one word per cycle while o_out.ready is high, set by
// the single multiplier per lane. When o_out.ready is low the stages fill up
// in turn; i_in.ready drops only once every stage holds a word. Synchronous
// reset clears stage valid bits, sets target and current gain to unity (65536).
module gain_ramp_linear_stereo import gls_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_wr_en,
    input  t_gain i_cfg_wr_data,
    gls_in_if.sink    i_in,
    gls_out_if.source o_out
);

    logic       r_v1, r_v2, r_v3;
    t_gain      r_gain;
    t_sample    r_samp [NumLanes];
    logic       en1, en2, en3, accept;
    t_ramp_stat stat;
    t_lane_ctrl ctrl;
    t_sample    lane_in  [NumLanes];
    t_sample    lane_out [NumLanes];

    assign en3    = !r_v3 || o_out.ready;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign accept = i_in.valid && en1;
    assign i_in.ready = en1;

    assign ctrl.load_prod = r_v1 && en2;
    assign ctrl.load_out  = r_v2 && en3;

    gls_ramp u_ramp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .o_stat        (stat)
    );

    assign lane_in[0] = i_in.sample_low;
    assign lane_in[1] = i_in.sample_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= accept && !stat.drop;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // hold the pair and its ramped gain for the multiply stage
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_gain <= stat.gain;
            for (int i = 0; i < NumLanes; i++) begin
                r_samp[i] <= lane_in[i];
            end
        end
    end

    for (genvar g = 0; g < NumLanes; g++) begin : g_lane
        gls_lane u_lane (
            .i_clk    (i_clk),
            .i_ctrl   (ctrl),
            .i_gain   (r_gain),
            .i_sample (r_samp[g]),
            .o_sample (lane_out[g])
        );
    end

    // merge lane results into the output word
    assign o_out.valid    = r_v3;
    assign o_out.out_low  = lane_out[0];
    assign o_out.out_high = lane_out[1];

endmodule
